### rtl/core/assert_macros.svh
// Assertion macros shared by the trajectory evaluator RTL.
// Each macro expects signals named clk and rst in the scope of its use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked at every rising edge outside reset.
`define CBTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define CBTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

### rtl/core/cbte_pkg.sv
// ----------------------------------------------------------------------------
// cbte_pkg
// Types, widths and helper functions of the cubic Bezier trajectory evaluator.
// ----------------------------------------------------------------------------
package cbte_pkg;

  localparam int COORD_W     = 32;
  localparam int FRAC_W      = 16;
  localparam int PHASE_W     = FRAC_W + 1;
  localparam int TIME_W      = 32;
  localparam int TIME_FRAC_W = 16;
  localparam int SEL_W       = 4;
  localparam int NUM_ENTRIES = 9;
  localparam int NUM_AXES    = 3;
  localparam int NUM_DIVS    = 2 * NUM_AXES;

  // Weights reach three times one, so two bits above the phase width.
  localparam int WGT_W  = PHASE_W + 2;
  localparam int PROD_W = COORD_W + WGT_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int CRV_W  = SUM_W - FRAC_W;

  // Quotient bits below the saturation point, and the divider widths.
  localparam int QUO_W      = COORD_W - 1;
  localparam int NUM_W      = CRV_W + 2 * TIME_FRAC_W;
  localparam int DEN_W      = 2 * TIME_W;
  localparam int DIV_STAGES = QUO_W + 1;

  // Bernstein coefficients of the cubic and quadratic middle terms.
  localparam int CUBIC_K = 3;
  localparam int QUAD_K  = 2;

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_W;
  localparam logic [SUM_W-1:0]   SUM_HALF  = SUM_W'(1) << (FRAC_W - 1);

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic [SEL_W-1:0]          point_select;
    logic signed [COORD_W-1:0] value_x;
    logic signed [COORD_W-1:0] value_y;
    logic signed [COORD_W-1:0] value_z;
    logic [PHASE_W-1:0]        phase;
    logic [TIME_W-1:0]         swing_time;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] vel_x;
    logic signed [COORD_W-1:0] vel_y;
    logic signed [COORD_W-1:0] vel_z;
    logic signed [COORD_W-1:0] acc_x;
    logic signed [COORD_W-1:0] acc_y;
    logic signed [COORD_W-1:0] acc_z;
    logic                      time_zero;
  } out_t;

  typedef struct packed {
    logic             vld;
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_in_t;

  typedef struct packed {
    logic             vld;
    logic             neg;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_out_t;

  // Round a Q2.32 product back to Q1.16, half up.
  function automatic logic [PHASE_W-1:0] rnd_frac(input logic [2*PHASE_W-1:0] p);
    logic [2*PHASE_W:0] s;
    s = {1'b0, p} + (2*PHASE_W+1)'(SUM_HALF);
    return s[FRAC_W +: PHASE_W];
  endfunction

  // Clamp a curve value to the signed coordinate range.
  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [CRV_W-1:0] q
  );
    logic signed [CRV_W-1:0] hi_lim;
    logic signed [CRV_W-1:0] lo_lim;
    hi_lim = CRV_W'(COORD_MAX);
    lo_lim = CRV_W'(COORD_MIN);
    if (q > hi_lim) begin
      return COORD_MAX;
    end else if (q < lo_lim) begin
      return COORD_MIN;
    end else begin
      return q[COORD_W-1:0];
    end
  endfunction

  // Apply sign and saturation to a divider result.
  function automatic logic signed [COORD_W-1:0] div_fmt(input div_out_t d);
    logic [COORD_W-1:0] mag;
    mag = {1'b0, d.quo};
    if (d.ovf) begin
      return d.neg ? COORD_MIN : COORD_MAX;
    end else begin
      return d.neg ? -mag : mag;
    end
  endfunction

endpackage

### rtl/core/cbte_div.sv
// ----------------------------------------------------------------------------
// cbte_div
// Pipelined restoring divider: one quotient bit per stage, with an up-front
// check that flags quotients too large for the signed coordinate range.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbte_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  cbte_pkg::div_in_t  din,
  output cbte_pkg::div_out_t dout
);

  localparam int LAST = cbte_pkg::DIV_STAGES - 1;
  localparam int HI_W = cbte_pkg::NUM_W - cbte_pkg::QUO_W;

  logic                         vld [cbte_pkg::DIV_STAGES];
  logic                         neg [cbte_pkg::DIV_STAGES];
  logic                         ovf [cbte_pkg::DIV_STAGES];
  logic [cbte_pkg::DEN_W-1:0]   rem [cbte_pkg::DIV_STAGES];
  logic [cbte_pkg::DEN_W-1:0]   den [cbte_pkg::DIV_STAGES];
  logic [cbte_pkg::QUO_W-1:0]   low [cbte_pkg::DIV_STAGES];
  logic [cbte_pkg::QUO_W-1:0]   quo [cbte_pkg::DIV_STAGES];
  logic [HI_W-1:0]              hi;

  // The upper numerator bits decide overflow and seed the remainder.
  assign hi = din.num[cbte_pkg::NUM_W-1:cbte_pkg::QUO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= din.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg[0] <= din.neg;
      ovf[0] <= cbte_pkg::DEN_W'(hi) >= din.den;
      rem[0] <= cbte_pkg::DEN_W'(hi);
      den[0] <= din.den;
      low[0] <= din.num[cbte_pkg::QUO_W-1:0];
      quo[0] <= '0;
    end
  end

  // Each stage shifts in one numerator bit and tries one subtract.
  for (genvar s = 1; s < cbte_pkg::DIV_STAGES; s++) begin : g_step
    logic [cbte_pkg::DEN_W:0] shifted;
    logic [cbte_pkg::DEN_W:0] diff;
    logic                     ge;

    assign shifted = {rem[s-1], low[s-1][cbte_pkg::QUO_W-1]};
    assign diff    = shifted - {1'b0, den[s-1]};
    assign ge      = shifted >= {1'b0, den[s-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg[s] <= neg[s-1];
        ovf[s] <= ovf[s-1];
        den[s] <= den[s-1];
        rem[s] <= ge ? diff[cbte_pkg::DEN_W-1:0] : shifted[cbte_pkg::DEN_W-1:0];
        low[s] <= low[s-1] << 1;
        quo[s] <= {quo[s-1][cbte_pkg::QUO_W-2:0], ge};
      end
    end
  end

  assign dout.vld = vld[LAST];
  assign dout.neg = neg[LAST];
  assign dout.ovf = ovf[LAST];
  assign dout.quo = quo[LAST];

  // A quotient in range leaves a proper remainder behind.
  `CBTE_ASSERT(a_rem_below_den, vld[LAST] && !ovf[LAST] |-> rem[LAST] < den[LAST], "divider remainder not below divisor")
  // A held pipeline keeps its last valid bit.
  `CBTE_ASSERT(a_hold_vld, !en |=> $stable(vld[LAST]), "divider moved while held")
  // A valid quotient always carries a known overflow flag.
  `CBTE_ASSERT(a_ovf_known, vld[LAST] |-> !$isunknown(ovf[LAST]), "divider overflow flag unknown")

endmodule

### rtl/core/cubic_bezier_trajectory_eval.sv
// ----------------------------------------------------------------------------
// cubic_bezier_trajectory_eval
// Cubic Bezier position with velocity and acceleration per unit time.
// ----------------------------------------------------------------------------
// Load beats write one of nine control points into a small table; evaluate
// beats produce one result beat each. The block takes one beat per cycle while
// the output is not stalled. An evaluate beat snapshots the table as it is
// accepted, so a load takes effect for every evaluate beat that follows it. A
// result passes through five stages of weight and dot product arithmetic, then
// a 32-stage pipelined divider (an overflow check followed by one quotient bit
// per stage) for the division by swing time and swing time squared, then the
// output register. A stall on the output holds the whole pipeline.
`include "assert_macros.svh"

module cubic_bezier_trajectory_eval (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  cbte_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output cbte_pkg::out_t  out_data
);

  localparam int CW   = cbte_pkg::COORD_W;
  localparam int PW   = cbte_pkg::PHASE_W;
  localparam int AX   = cbte_pkg::NUM_AXES;
  localparam int NE   = cbte_pkg::NUM_ENTRIES;
  localparam int LAST = cbte_pkg::DIV_STAGES - 1;

  logic adv;
  logic in_acc;

  logic signed [CW-1:0] tbl [NE][AX];

  logic [PW-1:0] t_clamp;
  logic [PW-1:0] mt_c;

  // Weight pipeline.
  logic                          v1, v2, v3, v4, v5;
  logic [PW-1:0]                 s1_t, s1_mt, s2_t, s2_mt;
  logic [2*PW-1:0]               s1_tt, s1_mm, s1_mtt;
  logic [PW-1:0]                 s2_t2, s2_mt2, s2_mtq;
  logic [2*PW-1:0]               s2_pt3, s2_pmt3, s2_pc1, s2_pc2;
  logic [cbte_pkg::WGT_W-1:0]    s3_w [NE];
  logic [cbte_pkg::TIME_W-1:0]   s1_tm, s2_tm, s3_tm, s4_tm, s5_tm;
  logic [cbte_pkg::DEN_W-1:0]    s1_tm2, s2_tm2, s3_tm2, s4_tm2, s5_tm2;
  logic signed [CW-1:0]          s1_pts [NE][AX];
  logic signed [CW-1:0]          s2_pts [NE][AX];
  logic signed [CW-1:0]          s3_pts [NE][AX];
  logic signed [cbte_pkg::PROD_W-1:0] s4_prod [NE][AX];
  logic signed [cbte_pkg::CRV_W-1:0]  s5_qc [AX];
  logic signed [cbte_pkg::CRV_W-1:0]  s5_qq [AX];
  logic signed [cbte_pkg::CRV_W-1:0]  s5_ql [AX];

  logic [PW-1:0] t2_c, mt2_c, mtq_c;

  // Divider lanes: velocity for each axis, then acceleration for each axis.
  cbte_pkg::div_in_t  div_in  [cbte_pkg::NUM_DIVS];
  cbte_pkg::div_out_t div_out [cbte_pkg::NUM_DIVS];

  // Position and zero-time flag ride alongside the divider.
  logic signed [CW-1:0] dly_pos [cbte_pkg::DIV_STAGES][AX];
  logic                 dly_tz  [cbte_pkg::DIV_STAGES];

  // The pipeline moves whenever the output register can take a beat.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;

  // Control point table, read as a whole into the pipeline on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < NE; e++) begin
        for (int a = 0; a < AX; a++) begin
          tbl[e][a] <= '0;
        end
      end
    end else if (in_acc && in_data.op == cbte_pkg::OP_LOAD &&
                 in_data.point_select < cbte_pkg::SEL_W'(NE)) begin
      tbl[in_data.point_select][0] <= in_data.value_x;
      tbl[in_data.point_select][1] <= in_data.value_y;
      tbl[in_data.point_select][2] <= in_data.value_z;
    end
  end

  // Phase above one is treated as one.
  assign t_clamp = (in_data.phase > cbte_pkg::PHASE_ONE) ? cbte_pkg::PHASE_ONE
                                                         : in_data.phase;
  assign mt_c    = cbte_pkg::PHASE_ONE - t_clamp;

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= in_acc && in_data.op == cbte_pkg::OP_EVAL;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Stage one: squares and cross product of the phase, time squared.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_t   <= t_clamp;
      s1_mt  <= mt_c;
      s1_tt  <= t_clamp * t_clamp;
      s1_mm  <= mt_c * mt_c;
      s1_mtt <= mt_c * t_clamp;
      s1_tm  <= in_data.swing_time;
      s1_tm2 <= in_data.swing_time * in_data.swing_time;
      s1_pts <= tbl;
    end
  end

  assign t2_c  = cbte_pkg::rnd_frac(s1_tt);
  assign mt2_c = cbte_pkg::rnd_frac(s1_mm);
  assign mtq_c = cbte_pkg::rnd_frac(s1_mtt);

  // Stage two: the cubic products.
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_t    <= s1_t;
      s2_mt   <= s1_mt;
      s2_t2   <= t2_c;
      s2_mt2  <= mt2_c;
      s2_mtq  <= mtq_c;
      s2_pt3  <= t2_c * s1_t;
      s2_pmt3 <= mt2_c * s1_mt;
      s2_pc1  <= mt2_c * s1_t;
      s2_pc2  <= s1_mt * t2_c;
      s2_tm   <= s1_tm;
      s2_tm2  <= s1_tm2;
      s2_pts  <= s1_pts;
    end
  end

  // Stage three: the nine basis weights.
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_w[0] <= cbte_pkg::WGT_W'(cbte_pkg::rnd_frac(s2_pmt3));
      s3_w[1] <= cbte_pkg::WGT_W'(cbte_pkg::rnd_frac(s2_pc1)) *
                 cbte_pkg::WGT_W'(cbte_pkg::CUBIC_K);
      s3_w[2] <= cbte_pkg::WGT_W'(cbte_pkg::rnd_frac(s2_pc2)) *
                 cbte_pkg::WGT_W'(cbte_pkg::CUBIC_K);
      s3_w[3] <= cbte_pkg::WGT_W'(cbte_pkg::rnd_frac(s2_pt3));
      s3_w[4] <= cbte_pkg::WGT_W'(s2_mt2);
      s3_w[5] <= cbte_pkg::WGT_W'(s2_mtq) * cbte_pkg::WGT_W'(cbte_pkg::QUAD_K);
      s3_w[6] <= cbte_pkg::WGT_W'(s2_t2);
      s3_w[7] <= cbte_pkg::WGT_W'(s2_mt);
      s3_w[8] <= cbte_pkg::WGT_W'(s2_t);
      s3_tm   <= s2_tm;
      s3_tm2  <= s2_tm2;
      s3_pts  <= s2_pts;
    end
  end

  // Stage four: each control point times its weight.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < NE; e++) begin
        for (int a = 0; a < AX; a++) begin
          s4_prod[e][a] <= s3_pts[e][a] * $signed({1'b0, s3_w[e]});
        end
      end
      s4_tm  <= s3_tm;
      s4_tm2 <= s3_tm2;
    end
  end

  // Stage five: sums per curve, rounded back to the coordinate scale.
  always_ff @(posedge clk) begin
    logic signed [cbte_pkg::SUM_W-1:0] cub;
    logic signed [cbte_pkg::SUM_W-1:0] qud;
    logic signed [cbte_pkg::SUM_W-1:0] lin;
    if (adv) begin
      for (int a = 0; a < AX; a++) begin
        cub = cbte_pkg::SUM_W'(s4_prod[0][a]) + cbte_pkg::SUM_W'(s4_prod[1][a]) +
              cbte_pkg::SUM_W'(s4_prod[2][a]) + cbte_pkg::SUM_W'(s4_prod[3][a]) +
              $signed(cbte_pkg::SUM_HALF);
        qud = cbte_pkg::SUM_W'(s4_prod[4][a]) + cbte_pkg::SUM_W'(s4_prod[5][a]) +
              cbte_pkg::SUM_W'(s4_prod[6][a]) + $signed(cbte_pkg::SUM_HALF);
        lin = cbte_pkg::SUM_W'(s4_prod[7][a]) + cbte_pkg::SUM_W'(s4_prod[8][a]) +
              $signed(cbte_pkg::SUM_HALF);
        s5_qc[a] <= cub[cbte_pkg::SUM_W-1:cbte_pkg::FRAC_W];
        s5_qq[a] <= qud[cbte_pkg::SUM_W-1:cbte_pkg::FRAC_W];
        s5_ql[a] <= lin[cbte_pkg::SUM_W-1:cbte_pkg::FRAC_W];
      end
      s5_tm  <= s4_tm;
      s5_tm2 <= s4_tm2;
    end
  end

  // Divider operands: magnitude scaled by the time fraction, sign aside.
  always_comb begin
    logic [cbte_pkg::CRV_W-1:0] mag_v;
    logic [cbte_pkg::CRV_W-1:0] mag_a;
    for (int a = 0; a < AX; a++) begin
      mag_v = (s5_qq[a] < 0) ? cbte_pkg::CRV_W'(-s5_qq[a]) : cbte_pkg::CRV_W'(s5_qq[a]);
      mag_a = (s5_ql[a] < 0) ? cbte_pkg::CRV_W'(-s5_ql[a]) : cbte_pkg::CRV_W'(s5_ql[a]);
      div_in[a].vld      = v5;
      div_in[a].neg      = s5_qq[a] < 0;
      div_in[a].num      = cbte_pkg::NUM_W'({mag_v, {cbte_pkg::TIME_FRAC_W{1'b0}}});
      div_in[a].den      = cbte_pkg::DEN_W'(s5_tm);
      div_in[AX+a].vld   = v5;
      div_in[AX+a].neg   = s5_ql[a] < 0;
      div_in[AX+a].num   = {mag_a, {(2*cbte_pkg::TIME_FRAC_W){1'b0}}};
      div_in[AX+a].den   = s5_tm2;
    end
  end

  for (genvar d = 0; d < cbte_pkg::NUM_DIVS; d++) begin : g_div
    cbte_div u_div (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .din  (div_in[d]),
      .dout (div_out[d])
    );
  end

  // Delay line for position and the zero-time flag.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < AX; a++) begin
        dly_pos[0][a] <= cbte_pkg::sat_coord(s5_qc[a]);
      end
      dly_tz[0] <= s5_tm == '0;
      for (int i = 1; i < cbte_pkg::DIV_STAGES; i++) begin
        dly_pos[i] <= dly_pos[i-1];
        dly_tz[i]  <= dly_tz[i-1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= div_out[0].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.pos_x     <= dly_pos[LAST][0];
      out_data.pos_y     <= dly_pos[LAST][1];
      out_data.pos_z     <= dly_pos[LAST][2];
      out_data.vel_x     <= dly_tz[LAST] ? '0 : cbte_pkg::div_fmt(div_out[0]);
      out_data.vel_y     <= dly_tz[LAST] ? '0 : cbte_pkg::div_fmt(div_out[1]);
      out_data.vel_z     <= dly_tz[LAST] ? '0 : cbte_pkg::div_fmt(div_out[2]);
      out_data.acc_x     <= dly_tz[LAST] ? '0 : cbte_pkg::div_fmt(div_out[3]);
      out_data.acc_y     <= dly_tz[LAST] ? '0 : cbte_pkg::div_fmt(div_out[4]);
      out_data.acc_z     <= dly_tz[LAST] ? '0 : cbte_pkg::div_fmt(div_out[5]);
      out_data.time_zero <= dly_tz[LAST];
    end
  end

  // A zero swing time leaves no derivative behind.
  `CBTE_ASSERT(a_tz_zero_deriv, out_valid && out_data.time_zero |-> out_data.vel_x == '0 && out_data.vel_y == '0 && out_data.vel_z == '0 && out_data.acc_x == '0 && out_data.acc_y == '0 && out_data.acc_z == '0, "derivative nonzero with zero swing time")
  // A stalled result beat stays put.
  `CBTE_ASSERT(a_stall_holds, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result beat changed")
  // No result beat right after reset.
  `CBTE_ASSERT_ALWAYS(a_reset_quiet, $past(rst) |-> !out_valid, "result beat after reset")

endmodule
